[src/cmw_pkg.sv]
// Package for the column melt wipe mapper: constants, types and datapath functions.
package cmw_pkg;

    // Sizes of the offset store and of the fields.
    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 1023;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = COL_W + 1;
    localparam int ROW_W       = 10;
    localparam int OFF_W       = 11;
    localparam int TICK_W      = 4;
    localparam int RND_W       = 8;

    // Melt constants.
    localparam int FAST_LIMIT  = 16;
    localparam int SLOW_STEP   = 8;
    localparam int MIN_START   = -15;

    // Column count as held in the store, at counter width.
    localparam logic [CNT_W-1:0] MAX_COLUMNS_C = CNT_W'(MAX_COLUMNS);

    // Command codes carried in tuser.
    typedef enum logic [1:0] {
        CMD_SEED    = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_MAP     = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // Configuration register indexes.
    localparam logic CFG_COLUMN_COUNT  = 1'b0;
    localparam logic CFG_SCREEN_HEIGHT = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_SEED_WR,
        S_ADV_RD,
        S_ADV_WR,
        S_LOOKUP,
        S_LOOK_WAIT,
        S_OUT
    } state_t;

    typedef logic signed [OFF_W-1:0] offset_t;

    // Result of one melt tick on one column.
    typedef struct packed {
        logic    active;
        offset_t y;
    } step_t;

    // Byte modulo 3 through a reciprocal multiply; exact for all 8-bit values.
    function automatic logic [1:0] mod3(input logic [RND_W-1:0] v);
        logic [16:0] prod;
        logic [7:0]  q;
        logic [9:0]  r;
        prod = 17'(v) * 17'd171;
        q    = prod[16:9];
        r    = 10'(v) - 10'(q) * 10'd3;
        return r[1:0];
    endfunction

    // Start offset of a column from its random byte and the previous column.
    function automatic offset_t seed_value(input logic first_col,
                                           input logic [RND_W-1:0] rnd,
                                           input offset_t prev);
        logic signed [OFF_W:0] sum;
        offset_t               res;
        sum = 12'(prev) + $signed({10'd0, mod3(rnd)}) - 12'sd1;
        if (first_col)
        begin
            res = -$signed({7'd0, rnd[3:0]});
        end
        else if (sum > 12'sd0)
        begin
            res = '0;
        end
        else if (sum < 12'(MIN_START))
        begin
            res = OFF_W'(MIN_START);
        end
        else
        begin
            res = sum[OFF_W-1:0];
        end
        return res;
    endfunction

    // One tick of one column: wait upward, then fall toward the screen height.
    function automatic step_t melt_step(input offset_t y, input logic [ROW_W-1:0] h);
        logic signed [OFF_W:0] y_ext;
        logic signed [OFF_W:0] h_ext;
        logic signed [OFF_W:0] dy;
        logic signed [OFF_W:0] sum;
        step_t                 res;
        y_ext = 12'(y);
        h_ext = $signed({2'b00, h});
        dy    = (y_ext < 12'(FAST_LIMIT)) ? y_ext + 12'sd1 : 12'(SLOW_STEP);
        sum   = y_ext + dy;
        res.active = 1'b0;
        res.y      = y;
        if (y_ext < 12'sd0)
        begin
            res.active = 1'b1;
            res.y      = y + 11'sd1;
        end
        else if (y_ext < h_ext)
        begin
            res.active = 1'b1;
            res.y      = (sum >= h_ext) ? h_ext[OFF_W-1:0] : sum[OFF_W-1:0];
        end
        return res;
    endfunction

endpackage

[src/cmw_offset_ram.sv]
// Simple dual-port RAM with registered read data, holding the column offsets.
module cmw_offset_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 11
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[src/column_melt_wipe_mapper.sv]
// Top level of the column melt wipe mapper: stream ports, sequencer and result register.
//
// The block keeps one signed offset per pixel-pair column in a 256-entry RAM and serves
// one command at a time. A seed of column 0 writes its value at once; a seed of any other
// column first reads its left neighbor and then writes. A map or an unused command reads
// the stored offset. An advance walks every active column once per tick through one
// read-modify-write unit, a read step and then a write step for each column, and then
// reads the addressed column for its result.
// The input is ready again once the result has moved into the output register. Offsets
// are not cleared at reset: every column must be seeded before it is advanced or mapped.
module column_melt_wipe_mapper
    import cmw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    // Command stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: random_byte[7:0], tick_count[11:8], column[19:12], row[29:20], zero[31:30]
    input  logic [31:0] s_axis_tdata,
    // tuser: command[1:0]
    input  logic [1:0]  s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: finished[0], from_end_screen[1], source_row[11:2], offset_now[22:12], zero[23]
    output logic [23:0] m_axis_tdata
);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [CNT_W-1:0] column_count_reg;
    logic [ROW_W-1:0] screen_height_reg;

    // Latched command fields.
    cmd_t              cmd_reg;
    logic [RND_W-1:0]  rnd_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;

    // Advance loop counters and activity flag.
    logic [COL_W-1:0]  col_idx_reg;
    logic [TICK_W-1:0] tick_reg;
    logic              done_reg;

    // Result waiting for the output register.
    logic              res_fin_reg;
    logic              res_end_reg;
    logic [ROW_W-1:0]  res_src_reg;
    offset_t           res_off_reg;

    // Output register.
    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    // RAM ports.
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    offset_t           wr_data;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic [OFF_W-1:0]  rd_data;

    logic              s_fire;
    logic              out_free;
    logic [CNT_W-1:0]  n_active;
    logic              last_col;
    logic              last_tick;
    logic              adv_empty;
    cmd_t              s_cmd;
    offset_t           seed_v;
    step_t             step;
    offset_t           map_y;
    logic [ROW_W-1:0]  map_y0;

    assign s_cmd     = cmd_t'(s_axis_tuser);
    assign s_fire    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign cfg_ready = 1'b1;

    // Active columns limited to the store; the 10-bit height never exceeds MAX_ROWS.
    assign n_active  = (column_count_reg > MAX_COLUMNS_C) ? MAX_COLUMNS_C : column_count_reg;
    assign last_col  = ({1'b0, col_idx_reg} == n_active - CNT_W'(1));
    assign last_tick = (tick_reg == ticks_reg - TICK_W'(1));
    assign adv_empty = (s_axis_tdata[11:8] == '0) || (n_active == '0);

    // Shared datapath: seed value and one melt tick on the word just read.
    assign seed_v = seed_value(col_reg == '0, rnd_reg, $signed(rd_data));
    assign step   = melt_step($signed(rd_data), screen_height_reg);

    // Map: a waiting column counts as offset zero.
    assign map_y  = $signed(rd_data);
    assign map_y0 = map_y[OFF_W-1] ? '0 : map_y[ROW_W-1:0];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg  <= CNT_W'(160);
            screen_height_reg <= ROW_W'(200);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_COLUMN_COUNT:  column_count_reg  <= cfg_data[CNT_W-1:0];
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[ROW_W-1:0];
                default:           column_count_reg  <= column_count_reg;
            endcase
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    unique case (s_cmd)
                        CMD_SEED:    state_next = S_SEED;
                        CMD_ADVANCE: state_next = adv_empty ? S_LOOKUP : S_ADV_RD;
                        default:     state_next = S_LOOKUP;
                    endcase
                end
            end
            S_SEED:      state_next = (col_reg == '0) ? S_OUT : S_SEED_WR;
            S_SEED_WR:   state_next = S_OUT;
            S_ADV_RD:    state_next = S_ADV_WR;
            S_ADV_WR:    state_next = (last_col && last_tick) ? S_LOOKUP : S_ADV_RD;
            S_LOOKUP:    state_next = S_LOOK_WAIT;
            S_LOOK_WAIT: state_next = S_OUT;
            S_OUT:       state_next = out_free ? S_IDLE : S_OUT;
            default:     state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs: RAM control and input ready.
    always_comb
    begin
        s_axis_tready = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = col_reg;
        wr_data       = seed_v;
        rd_en         = 1'b0;
        rd_addr       = col_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            S_SEED:
            begin
                wr_en   = (col_reg == '0);
                rd_en   = (col_reg != '0);
                rd_addr = col_reg - COL_W'(1);
            end
            S_SEED_WR:
            begin
                wr_en = 1'b1;
            end
            S_ADV_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = col_idx_reg;
            end
            S_ADV_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = col_idx_reg;
                wr_data = step.y;
            end
            S_LOOKUP:
            begin
                rd_en = 1'b1;
            end
            S_LOOK_WAIT, S_OUT:
            begin
                wr_en = 1'b0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command latch, loop counters and activity flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_idx_reg <= '0;
            tick_reg    <= '0;
            done_reg    <= 1'b1;
        end
        else if (s_fire)
        begin
            col_idx_reg <= '0;
            tick_reg    <= '0;
            done_reg    <= 1'b1;
        end
        else if (state_reg == S_ADV_WR)
        begin
            if (step.active)
            begin
                done_reg <= 1'b0;
            end
            if (last_col)
            begin
                col_idx_reg <= '0;
                tick_reg    <= tick_reg + TICK_W'(1);
            end
            else
            begin
                col_idx_reg <= col_idx_reg + COL_W'(1);
            end
        end
    end

    // Input fields of the transaction in progress.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cmd_reg   <= s_cmd;
            rnd_reg   <= s_axis_tdata[7:0];
            ticks_reg <= s_axis_tdata[11:8];
            col_reg   <= s_axis_tdata[19:12];
            row_reg   <= s_axis_tdata[29:20];
        end
    end

    // Result assembly.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_SEED && col_reg == '0) || state_reg == S_SEED_WR)
        begin
            res_fin_reg <= 1'b0;
            res_end_reg <= 1'b0;
            res_src_reg <= '0;
            res_off_reg <= seed_v;
        end
        else if (state_reg == S_LOOK_WAIT)
        begin
            res_fin_reg <= (cmd_reg == CMD_ADVANCE) && done_reg;
            res_end_reg <= 1'b0;
            res_src_reg <= '0;
            res_off_reg <= map_y;
            if (cmd_reg == CMD_MAP)
            begin
                if (row_reg < map_y0)
                begin
                    res_end_reg <= 1'b1;
                    res_src_reg <= row_reg;
                end
                else
                begin
                    res_src_reg <= row_reg - map_y0;
                end
            end
        end
    end

    // Output register: loads when free, empties when the receiver takes the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            m_data_reg <= {1'b0, res_off_reg, res_src_reg, res_end_reg, res_fin_reg};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // Offset store.
    cmw_offset_ram #(
        .DEPTH (MAX_COLUMNS),
        .WIDTH (OFF_W)
    ) u_offset_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef ASSERT_OFF
    // A result appears only after the sequencer reaches its output step.
    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output step");

    // The column walk stays inside the active columns.
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV_WR) |-> ({1'b0, col_idx_reg} < n_active))
        else $error("advance column index beyond the column count");

    // The tick counter stays below the requested tick count during a walk.
    a_tick_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV_RD || state_reg == S_ADV_WR) |-> (tick_reg < ticks_reg))
        else $error("advance tick counter overran");

    // Only one command is in flight: the input closes after each transaction.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // An advance result never claims an end-screen pixel.
    a_fin_vs_map: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("finished and end-screen flags both set");
`endif

endmodule
